// ----- rtl/rasb_pkg.sv -----
// Shared types and constants for the run-length alpha sprite line blender.
package rasb_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned WidthW  = 12;
  localparam int unsigned RemW    = 17;
  localparam int unsigned WeightW = 5;
  localparam int unsigned LenW    = 8;
  localparam int unsigned ChW     = 5;

  localparam logic [WeightW-1:0] SkipWeight = 5'd31;
  localparam logic [WidthW-1:0]  WidthReset = 12'd256;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_SKIP  = 2'd2
  } action_t;

  typedef struct packed {
    logic [WordW-1:0] stream_word;
    logic [WordW-1:0] dest_pixel;
  } in_req_t;

  typedef struct packed {
    action_t          action;
    logic [WordW-1:0] pixel_out;
    logic [LenW-1:0]  skip_length;
    logic             line_end;
    logic [WordW-1:0] line_words;
  } out_req_t;

  // classified request passed from front to back
  typedef struct packed {
    action_t            action;
    logic [WeightW-1:0] weight;
    logic [WordW-1:0]   src;
    logic [WordW-1:0]   dest;
    logic [LenW-1:0]    skip_length;
    logic               line_end;
    logic [WordW-1:0]   line_words;
  } cmd_t;

endpackage

// ----- rtl/rle_alpha_sprite_line_blender.sv -----
// Top level: run-length sprite line decoder with alpha blend onto RGB555.
// Path: accepted requests are written to the mid queue, pass the combinational back end and enter the output queue.
// Throughput: one stream word per cycle while in_full is low; the front state update is a registered feedback loop.
// Mid and output queues hold MID_DEPTH + OUT_DEPTH requests (four by default) while results wait.
// Reset (rst_n low, synchronous): queues empty, line state rearmed, line_width = 256.
module rle_alpha_sprite_line_blender import rasb_pkg::*; #(
  parameter int unsigned MID_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [WidthW-1:0] cfg_data,
  input  logic              in_push,
  input  in_req_t           in_data,
  output logic              in_full,
  output logic              out_empty,
  input  logic              out_pop,
  output out_req_t          out_data
);

  logic     in_acc;
  cmd_t     front_cmd;
  cmd_t     mid_cmd;
  logic     mid_empty;
  logic     res_full;
  out_req_t back_res;

  assign in_acc = in_push && !in_full;

  rasb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_valid (in_acc),
    .req       (in_data),
    .cmd       (front_cmd)
  );

  rasb_fifo #(.T(cmd_t), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (front_cmd),
    .full      (in_full),
    .pop       (!res_full),
    .pop_data  (mid_cmd),
    .empty     (mid_empty)
  );

  rasb_back u_back (
    .cmd (mid_cmd),
    .res (back_res)
  );

  rasb_fifo #(.T(out_req_t), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (!mid_empty),
    .push_data (back_res),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

endmodule

// ----- rtl/rasb_fifo.sv -----
// Small register-based FIFO used between the stages and at the result side.
module rasb_fifo import rasb_pkg::*; #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     push_data,
  output logic full,
  input  logic pop,
  output T     pop_data,
  output logic empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  T              mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == FullCnt);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == LastIdx) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == LastIdx) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/rasb_front.sv -----
// Front end: run/line state tracking and classification of each stream word.
module rasb_front import rasb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [WidthW-1:0] cfg_data,
  input  logic              req_valid,
  input  in_req_t           req,
  output cmd_t              cmd
);

  logic                    expect_hdr_r, expect_hdr_nxt;
  logic [WeightW-1:0]      weight_r, weight_nxt;
  logic [LenW-1:0]         run_rem_r, run_rem_nxt;
  logic signed [RemW-1:0]  width_rem_r, width_rem_nxt;
  logic [WordW-1:0]        word_cnt_r, word_cnt_nxt;
  logic [WidthW-1:0]       line_width_r, line_width_nxt;

  logic [LenW-1:0]         hdr_len;
  logic [WeightW-1:0]      hdr_weight;
  logic signed [RemW-1:0]  width_after;
  logic [LenW-1:0]         run_dec;
  logic [WordW-1:0]        cnt_inc;
  logic                    line_done;

  assign hdr_len     = req.stream_word[15:8];
  // weights above 31 saturate to the skip code
  assign hdr_weight  = (req.stream_word[7:0] > {3'b000, SkipWeight}) ? SkipWeight
                                                                      : req.stream_word[4:0];
  assign width_after = width_rem_r - $signed({{(RemW-LenW){1'b0}}, hdr_len});
  assign run_dec     = run_rem_r - 1'b1;
  assign cnt_inc     = word_cnt_r + 1'b1;

  always_comb begin
    cmd             = '0;
    cmd.action      = ACT_NONE;
    cmd.src         = req.stream_word;
    cmd.dest        = req.dest_pixel;
    cmd.weight      = weight_r;
    cmd.line_words  = cnt_inc;
    expect_hdr_nxt  = expect_hdr_r;
    weight_nxt      = weight_r;
    run_rem_nxt     = run_rem_r;
    width_rem_nxt   = width_rem_r;
    word_cnt_nxt    = word_cnt_r;
    line_width_nxt  = line_width_r;
    line_done       = 1'b0;

    if (req_valid) begin
      word_cnt_nxt = cnt_inc;
      if (expect_hdr_r) begin
        width_rem_nxt = width_after;
        if (hdr_weight == SkipWeight) begin
          cmd.action      = ACT_SKIP;
          cmd.skip_length = hdr_len;
          line_done       = (width_after <= 0);
        end else if (hdr_len == '0) begin
          line_done       = (width_after <= 0);
        end else begin
          expect_hdr_nxt  = 1'b0;
          weight_nxt      = hdr_weight;
          run_rem_nxt     = hdr_len;
        end
      end else begin
        cmd.action  = ACT_WRITE;
        run_rem_nxt = run_dec;
        if (run_dec == '0) begin
          expect_hdr_nxt = 1'b1;
          line_done      = (width_rem_r <= 0);
        end
      end
      cmd.line_end = line_done;
      if (line_done) begin
        expect_hdr_nxt = 1'b1;
        weight_nxt     = '0;
        run_rem_nxt    = '0;
        width_rem_nxt  = $signed({{(RemW-WidthW){1'b0}}, line_width_r});
        word_cnt_nxt   = '0;
      end
    end
    if (cfg_we) begin
      line_width_nxt = cfg_data;
      // a new width applies at once only before the line's first word
      if (!req_valid && expect_hdr_r && word_cnt_r == '0) begin
        width_rem_nxt = $signed({{(RemW-WidthW){1'b0}}, cfg_data});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_hdr_r <= 1'b1;
      weight_r     <= '0;
      run_rem_r    <= '0;
      width_rem_r  <= $signed({{(RemW-WidthW){1'b0}}, WidthReset});
      word_cnt_r   <= '0;
      line_width_r <= WidthReset;
    end else begin
      expect_hdr_r <= expect_hdr_nxt;
      weight_r     <= weight_nxt;
      run_rem_r    <= run_rem_nxt;
      width_rem_r  <= width_rem_nxt;
      word_cnt_r   <= word_cnt_nxt;
      line_width_r <= line_width_nxt;
    end
  end

endmodule

// ----- rtl/rasb_back.sv -----
// Back end: per-channel premultiplied alpha blend and result formatting.
module rasb_back import rasb_pkg::*; (
  input  cmd_t     cmd,
  output out_req_t res
);

  logic [ChW-1:0]     dst_r5, dst_g5, dst_b5;
  logic [2*ChW-1:0]   prod_r, prod_g, prod_b;
  logic [WordW-1:0]   blended;

  assign dst_r5 = cmd.dest[4:0];
  assign dst_g5 = cmd.dest[9:5];
  assign dst_b5 = cmd.dest[14:10];

  assign prod_r = cmd.weight * dst_r5;
  assign prod_g = cmd.weight * dst_g5;
  assign prod_b = cmd.weight * dst_b5;

  // floor(w*c/32) per channel, shifted into place; carries wrap at 16 bits
  assign blended = cmd.src
                 + {11'd0, prod_r[9:5]}
                 + {6'd0, prod_g[9:5], 5'd0}
                 + {1'b0, prod_b[9:5], 10'd0};

  always_comb begin
    res             = '0;
    res.action      = cmd.action;
    res.skip_length = cmd.skip_length;
    res.line_end    = cmd.line_end;
    res.line_words  = cmd.line_words;
    case (cmd.action)
      ACT_WRITE: res.pixel_out = (cmd.weight <= 5'd1) ? cmd.src : blended;
      default:   res.pixel_out = '0;
    endcase
  end

endmodule

// ----- rtl/rasb_checker.sv -----
// Port-level checker for the sprite line blender, bound to the top level.
module rasb_checker import rasb_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_empty,
  input logic     out_pop,
  input out_req_t out_data
);

  // no result may appear right out of reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result present right after reset");

  a_action_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.action == ACT_NONE || out_data.action == ACT_WRITE ||
                    out_data.action == ACT_SKIP))
    else $error("illegal action code");

  a_pixel_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.action != ACT_WRITE) |-> out_data.pixel_out == '0)
    else $error("pixel_out nonzero without a write");

  a_skip_only_on_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.action != ACT_SKIP) |-> out_data.skip_length == '0)
    else $error("skip_length nonzero without a skip");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

endmodule

bind rle_alpha_sprite_line_blender rasb_checker u_rasb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
